// ===== hdl/assert_macros.svh =====
// Assertion helpers, included by uart_buffered_byte_queues_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ubq_pkg.sv =====
package ubq_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned RX_DEPTH_DF = 4;
  localparam int unsigned TX_DEPTH_DF = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LINE_RX = 2'd0,
    OP_TX_DONE = 2'd1,
    OP_SEND    = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  // Status of one ring: flags before the current request, level after it.
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [LEVEL_W-1:0] level_nxt;
  } ring_stat_t;

endpackage

// ===== hdl/ubq_ram.sv =====
module ubq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ubq_ring.sv =====
module ubq_ring import ubq_pkg::*; #(
  parameter int unsigned DEPTH = RX_DEPTH_DF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              pop_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o,
  output ring_stat_t        stat_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [PW-1:0] rd_q, rd_d;
  logic [PW-1:0] wr_q, wr_d;
  logic          full_q, full_d;
  logic [CW-1:0] level;
  logic [31:0]   level_ext;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr);
    advance = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_comb begin
    rd_d   = pop_i  ? advance(rd_q) : rd_q;
    wr_d   = push_i ? advance(wr_q) : wr_q;
    full_d = full_q;
    if (pop_i) begin
      full_d = 1'b0;
    end else if (push_i) begin
      full_d = (wr_d == rd_q);
    end
  end

  // Level after the request; the pointer difference is taken modulo the depth.
  always_comb begin
    if (full_d) begin
      level = CW'(DEPTH);
    end else begin
      level = CW'(wr_d) - CW'(rd_d) + ((wr_d < rd_d) ? CW'(DEPTH) : '0);
    end
    level_ext = 32'(level);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      full_q <= 1'b0;
    end else begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      full_q <= full_d;
    end
  end

  ubq_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push_i),
    .waddr_i(wr_q),
    .wdata_i(wdata_i),
    .re_i   (pop_i),
    .raddr_i(rd_q),
    .rdata_o(rdata_o)
  );

  assign stat_o.full      = full_q;
  assign stat_o.empty     = !full_q && (rd_q == wr_q);
  assign stat_o.level_nxt = level_ext[LEVEL_W-1:0];

endmodule

// ===== hdl/uart_buffered_byte_queues_core.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o   | op_i, data_byte_i
// out      | output    | out_valid_o / out_stall_i | accepted_o, out_byte_o, tx_start_o,
//          |           |                           | rx_level_o, tx_level_o
//
// A request that needs no ring read (line byte, send, refused or empty cases) is written to
// the output register in the cycle after it is accepted; a read or a transmit-done that pops a
// byte passes first through the registered read of the ring memory, then the output register.
// Reset clears pointers, flags and the output valid bit; the output payload and ring memories are not cleared.
// The input stalls while a ring read is outstanding and while a result waits on a stalled
// output; a result being taken frees the output register in the same cycle.
`include "assert_macros.svh"

module uart_buffered_byte_queues_core import ubq_pkg::*; #(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DF,
  parameter int unsigned TX_DEPTH = TX_DEPTH_DF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               tx_start_o,
  output logic [LEVEL_W-1:0] rx_level_o,
  output logic [LEVEL_W-1:0] tx_level_o
);

  op_e         op;
  logic        accept;
  logic        rx_push, rx_pop, tx_push, tx_pop;
  logic        send_direct, need_read;
  ring_stat_t  rx_stat, tx_stat;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  logic        idle_q, idle_d;
  logic        pend_q, pend_d;
  logic        pend_rx_q, pend_rx_d;
  logic        out_valid_q, out_valid_d;
  logic        accepted_q, accepted_d;
  logic        start_q, start_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic [LEVEL_W-1:0] rxl_q, rxl_d;
  logic [LEVEL_W-1:0] txl_q, txl_d;

  assign op         = op_e'(op_i);
  assign in_stall_o = pend_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    rx_push     = 1'b0;
    rx_pop      = 1'b0;
    tx_push     = 1'b0;
    tx_pop      = 1'b0;
    send_direct = 1'b0;
    idle_d      = idle_q;
    if (accept) begin
      unique case (op)
        OP_LINE_RX: rx_push = !rx_stat.full;
        OP_TX_DONE: begin
          tx_pop = !tx_stat.empty;
          idle_d = tx_stat.empty;
        end
        OP_SEND: begin
          tx_push = !tx_stat.full;
          // An idle transmitter always has an empty ring, so the byte goes out as is.
          send_direct = !tx_stat.full && idle_q;
          tx_pop      = send_direct;
          if (send_direct) begin
            idle_d = 1'b0;
          end
        end
        OP_READ: rx_pop = !rx_stat.empty;
        default: ;
      endcase
    end
  end

  assign need_read = rx_pop || (tx_pop && !send_direct);

  always_comb begin
    pend_d      = need_read;
    pend_rx_d   = need_read ? rx_pop : pend_rx_q;
    out_valid_d = out_valid_q && out_stall_i;
    accepted_d  = accepted_q;
    start_d     = start_q;
    byte_d      = byte_q;
    rxl_d       = rxl_q;
    txl_d       = txl_q;
    if (accept) begin
      out_valid_d = !need_read;
      accepted_d  = rx_push || rx_pop || tx_push || tx_pop;
      start_d     = tx_pop;
      byte_d      = send_direct ? data_byte_i : '0;
      rxl_d       = rx_stat.level_nxt;
      txl_d       = tx_stat.level_nxt;
    end else if (pend_q) begin
      out_valid_d = 1'b1;
      byte_d      = pend_rx_q ? rx_rdata : tx_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q      <= 1'b1;
      pend_q      <= 1'b0;
      pend_rx_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idle_q      <= idle_d;
      pend_q      <= pend_d;
      pend_rx_q   <= pend_rx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    accepted_q <= accepted_d;
    start_q    <= start_d;
    byte_q     <= byte_d;
    rxl_q      <= rxl_d;
    txl_q      <= txl_d;
  end

  ubq_ring #(
    .DEPTH(RX_DEPTH)
  ) u_rx_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rx_push),
    .pop_i  (rx_pop),
    .wdata_i(data_byte_i),
    .rdata_o(rx_rdata),
    .stat_o (rx_stat)
  );

  ubq_ring #(
    .DEPTH(TX_DEPTH)
  ) u_tx_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tx_push),
    .pop_i  (tx_pop),
    .wdata_i(data_byte_i),
    .rdata_o(tx_rdata),
    .stat_o (tx_stat)
  );

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign out_byte_o  = byte_q;
  assign tx_start_o  = start_q;
  assign rx_level_o  = rxl_q;
  assign tx_level_o  = txl_q;

  `ASSERT_CLK(a_pend_then_out, pend_q |=> out_valid_o, "ring read did not produce a result")
  `ASSERT_CLK(a_idle_empty, idle_q |-> tx_stat.empty, "transmitter idle with bytes queued")
  `ASSERT_CLK(a_start_accepted, out_valid_o && tx_start_o |-> accepted_o,
              "transmit start without accepted request")
  // The flags are unknown until the first reset edge, so reset itself satisfies the check.
  `ASSERT_ALWAYS(a_no_pend_with_out, !rst_ni || !(pend_q && out_valid_q),
                 "ring read pending while output register holds a result")

endmodule
